>>> hw/rtl/smtd_pkg.sv
package smtd_pkg;

    // default sizing of the delay line
    localparam int DEF_BUFFER_DEPTH = 65536;
    localparam int DEF_TAP_COUNT    = 32;
    localparam int DEF_SAMPLE_WIDTH = 24;

    // fixed field widths
    localparam int ACT_W   = 2;
    localparam int IDX_W   = 5;
    localparam int DELAY_W = 16;
    localparam int GAIN_W  = 16;

    // tap number, tap delay, tap enable and tap gain packed after the two samples
    localparam int CTL_FIELDS_W = IDX_W + DELAY_W + 1 + GAIN_W;

    // gain format, unsigned q3.13
    localparam int                GAIN_FRAC  = 13;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd8192;
    localparam int                ROUND_BIAS = 4096;

    // register reset
    localparam logic [DELAY_W-1:0] MAX_DELAY_RESET = 16'hFFFF;

    // action codes carried on tuser
    localparam logic [ACT_W-1:0] ACT_SAMPLE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET_DELAY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET_GAIN  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 2'd3;

    // sequencer to mac control
    typedef struct packed {
        logic clear;
        logic valid;
        logic hit;
    } mac_ctrl_t;

endpackage

>>> hw/rtl/smtd_mac.sv
module smtd_mac #(
    parameter int SAMPLE_WIDTH = smtd_pkg::DEF_SAMPLE_WIDTH,
    parameter int TAP_COUNT    = smtd_pkg::DEF_TAP_COUNT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  smtd_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]      left_smp,
    input  logic signed [SAMPLE_WIDTH-1:0]      right_smp,
    input  logic [smtd_pkg::GAIN_W-1:0]         gain,
    output logic signed [SAMPLE_WIDTH-1:0]      left_sum,
    output logic signed [SAMPLE_WIDTH-1:0]      right_sum
);
    import smtd_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + GAIN_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT + 1);
    localparam int Q_W    = ACC_W + 1 - GAIN_FRAC;

    logic signed [PROD_W-1:0] prod_l;
    logic signed [PROD_W-1:0] prod_r;
    logic signed [PROD_W-1:0] p_l_reg;
    logic signed [PROD_W-1:0] p_r_reg;
    logic signed [ACC_W-1:0]  acc_l_reg;
    logic signed [ACC_W-1:0]  acc_r_reg;
    logic                     p_clear_reg;

    // round half up, then saturate to the sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic [ACC_W:0]          b;
        logic signed [Q_W-1:0]   q;
        logic signed [Q_W-1:0]   hi;
        logic signed [Q_W-1:0]   lo;
        b  = {a[ACC_W-1], a} + (ACC_W + 1)'(ROUND_BIAS);
        q  = b[ACC_W:GAIN_FRAC];
        hi = Q_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
        lo = ~hi;
        if (q > hi) begin
            return hi[SAMPLE_WIDTH-1:0];
        end else if (q < lo) begin
            return lo[SAMPLE_WIDTH-1:0];
        end
        return q[SAMPLE_WIDTH-1:0];
    endfunction

    // one product per lane, gain taken as positive
    assign prod_l = left_smp  * $signed({1'b0, gain});
    assign prod_r = right_smp * $signed({1'b0, gain});

    // product stage, skipped taps give zero
    always_ff @(posedge aclk) begin
        if (ctrl.valid && ctrl.hit) begin
            p_l_reg <= prod_l;
            p_r_reg <= prod_r;
        end else begin
            p_l_reg <= '0;
            p_r_reg <= '0;
        end
    end

    // clear flag follows the product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_clear_reg <= 1'b0;
        end else begin
            p_clear_reg <= ctrl.clear;
        end
    end

    // accumulate stage
    always_ff @(posedge aclk) begin
        if (ctrl.clear || p_clear_reg) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else begin
            acc_l_reg <= acc_l_reg + ACC_W'(p_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(p_r_reg);
        end
    end

    assign left_sum  = round_sat(acc_l_reg);
    assign right_sum = round_sat(acc_r_reg);

endmodule

>>> hw/rtl/stereo_multitap_delay_unit.sv
// a sample beat sweeps its taps, drains the pipeline and is registered in the
//   finish state, which holds while the output stalls; only then is a new beat taken
// one dual-lane mac takes one tap per cycle over the single memory read port
// set-delay beats run the reciprocal reduction of the delay; gain and clear do not
// reset: control, tap tables and max delay go to defaults; the delay memory reads
//   as zero through a fill count, so neither reset nor clear needs a sweep
module stereo_multitap_delay_unit #(
    parameter int BUFFER_DEPTH = smtd_pkg::DEF_BUFFER_DEPTH,
    parameter int TAP_COUNT    = smtd_pkg::DEF_TAP_COUNT,
    parameter int SAMPLE_WIDTH = smtd_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [smtd_pkg::DELAY_W-1:0]           cfg_wr_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // left_in, right_in, tap number, tap_delay, tap_on, tap_gain
    input  logic [((2*SAMPLE_WIDTH+smtd_pkg::CTL_FIELDS_W+7)/8)*8-1:0] s_tdata,
    // action
    input  logic [smtd_pkg::ACT_W-1:0]             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata
);
    import smtd_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int REM_W  = ADDR_W + 1;
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam int TAP_IW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int STEP_W = 1;
    localparam int RCP_W  = 33;
    localparam int RCP_SH = 32;
    localparam int M_W    = ((2*SAMPLE_WIDTH+7)/8)*8;
    localparam int F_IDX  = 2 * SAMPLE_WIDTH;
    localparam int F_DLY  = F_IDX + IDX_W;
    localparam int F_ON   = F_DLY + DELAY_W;
    localparam int F_GAIN = F_ON + 1;

    // ceiling reciprocal of the depth, exact quotient for any 16-bit delay
    localparam longint RCP_L = ((longint'(1) << RCP_SH) + BUFFER_DEPTH - 1) / BUFFER_DEPTH;

    localparam logic [TAP_IW-1:0] TAP_LAST  = TAP_IW'(TAP_COUNT - 1);
    localparam logic [IDX_W+1:0]  TAP_LIM   = (IDX_W + 2)'(TAP_COUNT);
    localparam logic [REM_W-1:0]  DEPTH_R   = REM_W'(BUFFER_DEPTH);
    localparam logic [ADDR_W-1:0] DEPTH_A   = ADDR_W'(BUFFER_DEPTH);
    localparam logic [ADDR_W-1:0] WP_LAST   = ADDR_W'(BUFFER_DEPTH - 1);
    localparam logic [FILL_W-1:0] DEPTH_F   = FILL_W'(BUFFER_DEPTH);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(1);
    localparam logic [RCP_W-1:0]  RCP       = RCP_W'(RCP_L);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TAPS   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_MOD    = 3'd4;

    // input fields
    logic signed [SAMPLE_WIDTH-1:0] in_left;
    logic signed [SAMPLE_WIDTH-1:0] in_right;
    logic [IDX_W-1:0]               in_idx;
    logic [DELAY_W-1:0]             in_delay;
    logic                           in_on;
    logic [GAIN_W-1:0]              in_gain;
    logic [IDX_W+1:0]               idx_ext;
    logic                           idx_ok;
    logic [TAP_IW-1:0]              in_tap;
    logic                           accept;
    logic                           acc_sample;
    logic                           out_free;

    // control state
    logic [2:0]        state_reg,    state_next;
    logic [TAP_IW-1:0] tap_cnt_reg,  tap_cnt_next;
    logic [STEP_W-1:0] step_reg,     step_next;
    logic              drain_reg,    drain_next;
    logic [ADDR_W-1:0] wp_reg,       wp_next;
    logic [FILL_W-1:0] fill_reg,     fill_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DELAY_W-1:0] max_delay_reg;

    // tap tables
    logic [DELAY_W-1:0] delay_raw_reg [TAP_COUNT];
    logic [ADDR_W-1:0]  delay_mod_reg [TAP_COUNT];
    logic [GAIN_W-1:0]  gain_reg      [TAP_COUNT];
    logic               enable_reg    [TAP_COUNT];

    // delay reduction
    logic [TAP_IW-1:0]        mod_tap_reg;
    logic [DELAY_W-1:0]       dsh_reg;
    logic [DELAY_W-1:0]       quo_reg;
    logic [DELAY_W+RCP_W-1:0] quo_prod;
    logic [DELAY_W-1:0]       rem_full;
    logic [ADDR_W-1:0]        rem_new;

    // tap lookup
    logic [DELAY_W-1:0] t_raw;
    logic [ADDR_W-1:0]  t_dr;
    logic               t_hit;
    logic [ADDR_W:0]    rd_sub;
    logic [ADDR_W-1:0]  rd_addr;

    // delay memory and read stage
    logic [2*SAMPLE_WIDTH-1:0] delay_mem [BUFFER_DEPTH];
    logic [2*SAMPLE_WIDTH-1:0] rd_data_reg;
    logic                      s1_valid_reg;
    logic                      s1_hit_reg;
    logic [GAIN_W-1:0]         s1_gain_reg;

    // mac
    mac_ctrl_t                      mac_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] left_sum;
    logic signed [SAMPLE_WIDTH-1:0] right_sum;
    logic signed [SAMPLE_WIDTH-1:0] left_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_out_reg;

    // unpack the input beat
    assign in_left  = s_tdata[SAMPLE_WIDTH-1:0];
    assign in_right = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign in_idx   = s_tdata[F_IDX +: IDX_W];
    assign in_delay = s_tdata[F_DLY +: DELAY_W];
    assign in_on    = s_tdata[F_ON];
    assign in_gain  = s_tdata[F_GAIN +: GAIN_W];
    assign idx_ext  = {2'b00, in_idx};
    assign idx_ok   = idx_ext < TAP_LIM;
    assign in_tap   = idx_ext[TAP_IW-1:0];

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign acc_sample = accept && (s_tuser == ACT_SAMPLE);
    assign out_free   = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        tap_cnt_next  = tap_cnt_reg;
        step_next     = step_reg;
        drain_next    = drain_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        ACT_SAMPLE: begin
                            state_next   = ST_TAPS;
                            tap_cnt_next = '0;
                            if (fill_reg < DEPTH_F) begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        ACT_SET_DELAY: begin
                            if (idx_ok) begin
                                state_next = ST_MOD;
                                step_next  = '0;
                            end
                        end
                        ACT_CLEAR: begin
                            fill_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TAPS: begin
                tap_cnt_next = tap_cnt_reg + 1'b1;
                if (tap_cnt_reg == TAP_LAST) begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
            end
            ST_DRAIN: begin
                if (drain_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    drain_next = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    wp_next       = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
                end
            end
            ST_MOD: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tap_cnt_reg  <= '0;
            step_reg     <= '0;
            drain_reg    <= 1'b0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_cnt_reg  <= tap_cnt_next;
            step_reg     <= step_next;
            drain_reg    <= drain_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // max delay register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_delay_reg <= MAX_DELAY_RESET;
        end else if (cfg_wr_en) begin
            max_delay_reg <= cfg_wr_data;
        end
    end

    // delay reduced by the memory depth: reciprocal multiply for the quotient,
    // then one multiply-subtract for the remainder on the next cycle
    assign quo_prod = dsh_reg * RCP;
    assign rem_full = dsh_reg - DELAY_W'(quo_reg * DEPTH_R);
    assign rem_new  = ADDR_W'(rem_full);

    always_ff @(posedge aclk) begin
        if (accept) begin
            mod_tap_reg <= in_tap;
            dsh_reg     <= in_delay;
        end else if ((state_reg == ST_MOD) && (step_reg == '0)) begin
            quo_reg <= quo_prod[RCP_SH +: DELAY_W];
        end
    end

    // tap tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAP_COUNT; i++) begin
                delay_raw_reg[i] <= '0;
                delay_mod_reg[i] <= '0;
                gain_reg[i]      <= UNITY_GAIN;
                enable_reg[i]    <= 1'b0;
            end
        end else begin
            if (accept && (s_tuser == ACT_SET_DELAY) && idx_ok) begin
                delay_raw_reg[in_tap] <= in_delay;
                enable_reg[in_tap]    <= in_on;
            end
            if (accept && (s_tuser == ACT_SET_GAIN) && idx_ok) begin
                gain_reg[in_tap] <= in_gain;
            end
            if ((state_reg == ST_MOD) && (step_reg == STEP_LAST)) begin
                delay_mod_reg[mod_tap_reg] <= rem_new;
            end
        end
    end

    // tap lookup: skip disabled, too long, or not yet written since clear
    assign t_raw   = delay_raw_reg[tap_cnt_reg];
    assign t_dr    = delay_mod_reg[tap_cnt_reg];
    assign t_hit   = enable_reg[tap_cnt_reg] && (t_raw <= max_delay_reg)
                     && (FILL_W'(t_dr) < fill_reg);
    assign rd_sub  = {1'b0, wp_reg} - {1'b0, t_dr};
    assign rd_addr = rd_sub[ADDR_W] ? rd_sub[ADDR_W-1:0] + DEPTH_A : rd_sub[ADDR_W-1:0];

    // delay memory, sample written on the accepting edge
    always_ff @(posedge aclk) begin
        if (acc_sample) begin
            delay_mem[wp_reg] <= {in_right, in_left};
        end
        rd_data_reg <= delay_mem[rd_addr];
    end

    // read stage alongside the memory output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_hit_reg   <= 1'b0;
        end else begin
            s1_valid_reg <= (state_reg == ST_TAPS);
            s1_hit_reg   <= t_hit;
        end
    end

    always_ff @(posedge aclk) begin
        s1_gain_reg <= gain_reg[tap_cnt_reg];
    end

    assign mac_ctrl.clear = acc_sample;
    assign mac_ctrl.valid = s1_valid_reg;
    assign mac_ctrl.hit   = s1_hit_reg;

    smtd_mac #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .TAP_COUNT   (TAP_COUNT)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .left_smp (rd_data_reg[SAMPLE_WIDTH-1:0]),
        .right_smp(rd_data_reg[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .gain     (s1_gain_reg),
        .left_sum (left_sum),
        .right_sum(right_sum)
    );

    // output register
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FINISH) && out_free) begin
            left_out_reg  <= left_sum;
            right_out_reg <= right_sum;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_W'({right_out_reg, left_out_reg});

endmodule

>>> hw/rtl/smtd_checker.sv
module smtd_checker #(
    parameter int SAMPLE_WIDTH = smtd_pkg::DEF_SAMPLE_WIDTH
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [smtd_pkg::ACT_W-1:0]         s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);
    import smtd_pkg::*;

    // no result beat right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // an accepted sample beat closes the input as its taps start
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_SAMPLE) |=> !s_tready)
        else $error("input open during tap sweep");

    // non-sample beats never produce a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != ACT_SAMPLE) && !m_tvalid |=> !m_tvalid)
        else $error("result from a non-sample beat");

    // a new result only appears after the input was closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a tap sweep");

endmodule

bind stereo_multitap_delay_unit smtd_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_smtd_checker (.*);

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smtd_pkg::*;

    localparam int     SW            = DEF_SAMPLE_WIDTH;
    localparam int     TAPS          = DEF_TAP_COUNT;
    localparam int     S_DATA_W      = ((2*SW + CTL_FIELDS_W + 7)/8)*8;
    localparam int     M_DATA_W      = ((2*SW + 7)/8)*8;
    localparam longint SAT_HI        = (longint'(1) <<< (SW-1)) - 1;
    localparam longint SAT_LO        = -SAT_HI - 1;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     HOLD_CYCLES   = 320;
    localparam int     REPORT_LIMIT  = 10;
    localparam longint LIMIT_NS      = 20_000_000;

    typedef logic signed [SW-1:0] sample_t;

    // input beat fields, first declared sits in the top bits
    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic               on;
        logic [DELAY_W-1:0] lag;
        logic [IDX_W-1:0]   index;
        sample_t            right;
        sample_t            left;
    } beat_fields_t;

    typedef struct packed {
        sample_t right;
        sample_t left;
    } stereo_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [DELAY_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;

    // shadow state of the delay line
    sample_t              echo_left  [DEF_BUFFER_DEPTH];
    sample_t              echo_right [DEF_BUFFER_DEPTH];
    logic [DELAY_W-1:0]   write_pos;   // wraps at 65536, the buffer depth
    logic [DELAY_W-1:0]   tap_lag  [TAPS];
    logic [GAIN_W-1:0]    tap_gain [TAPS];
    logic                 tap_live [TAPS];
    logic [DELAY_W-1:0]   max_lag;

    stereo_t              expected_mix[$];

    int  fail_count    = 0;
    int  mix_checked   = 0;
    int  samples_sent  = 0;
    int  tap_writes    = 0;
    int  clears_sent   = 0;
    int  cfg_writes    = 0;
    bit  gaps_on       = 1'b1;
    bit  stalls_on     = 1'b1;
    bit  hold_request  = 1'b0;

    stereo_multitap_delay_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("timeout: %0d results still pending", expected_mix.size());
        $display("testbench: done, errors");
        $finish;
    end

    // round half up, then clip to the sample range
    function automatic sample_t round_and_clip(input longint acc);
        longint q;
        q = (acc + ROUND_BIAS) >>> GAIN_FRAC;
        if (q > SAT_HI) q = SAT_HI;
        if (q < SAT_LO) q = SAT_LO;
        return sample_t'(q);
    endfunction

    task automatic reset_echo_model();
        foreach (echo_left[i]) begin
            echo_left[i]  = '0;
            echo_right[i] = '0;
        end
        foreach (tap_lag[t]) begin
            tap_lag[t]  = '0;
            tap_gain[t] = UNITY_GAIN;
            tap_live[t] = 1'b0;
        end
        write_pos = '0;
        max_lag   = MAX_DELAY_RESET;
    endtask

    // apply one accepted beat to the shadow state, queue the mix it produces
    task automatic advance_echo_model(input logic [ACT_W-1:0] act, input beat_fields_t f);
        longint             acc_l;
        longint             acc_r;
        logic [DELAY_W-1:0] pos;
        stereo_t            mix;
        acc_l = 0;
        acc_r = 0;
        case (act)
            ACT_SET_DELAY: begin
                tap_lag[f.index]  = f.lag;
                tap_live[f.index] = f.on;
                tap_writes++;
            end
            ACT_SET_GAIN: begin
                tap_gain[f.index] = f.gain;
                tap_writes++;
            end
            ACT_CLEAR: begin
                foreach (echo_left[i]) begin
                    echo_left[i]  = '0;
                    echo_right[i] = '0;
                end
                clears_sent++;
            end
            ACT_SAMPLE: begin
                // write first so a zero lag sees the current frame
                echo_left[write_pos]  = f.left;
                echo_right[write_pos] = f.right;
                for (int t = 0; t < TAPS; t++) begin
                    if (tap_live[t] && tap_lag[t] <= max_lag) begin
                        pos   = write_pos - tap_lag[t];
                        acc_l += longint'(echo_left[pos])  * longint'(tap_gain[t]);
                        acc_r += longint'(echo_right[pos]) * longint'(tap_gain[t]);
                    end
                end
                write_pos++;
                mix.left  = round_and_clip(acc_l);
                mix.right = round_and_clip(acc_r);
                expected_mix.push_back(mix);
                samples_sent++;
            end
        endcase
    endtask

    // offer one beat, hold it until accepted, then predict
    task automatic send_beat(input logic [ACT_W-1:0] act, input beat_fields_t f);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(f);
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_echo_model(act, f);
    endtask

    // unused fields carry random bits
    function automatic beat_fields_t random_fields();
        beat_fields_t f;
        f.left  = sample_t'($urandom);
        f.right = sample_t'($urandom);
        f.index = IDX_W'($urandom);
        f.lag   = DELAY_W'($urandom);
        f.on    = 1'($urandom);
        f.gain  = GAIN_W'($urandom);
        return f;
    endfunction

    task automatic send_sample(input sample_t l, input sample_t r);
        beat_fields_t f;
        f = random_fields();
        f.left  = l;
        f.right = r;
        send_beat(ACT_SAMPLE, f);
    endtask

    task automatic send_tap(input int idx, input logic [DELAY_W-1:0] lag, input logic on);
        beat_fields_t f;
        f = random_fields();
        f.index = IDX_W'(idx);
        f.lag   = lag;
        f.on    = on;
        send_beat(ACT_SET_DELAY, f);
    endtask

    task automatic send_gain(input int idx, input logic [GAIN_W-1:0] g);
        beat_fields_t f;
        f = random_fields();
        f.index = IDX_W'(idx);
        f.gain  = g;
        send_beat(ACT_SET_GAIN, f);
    endtask

    task automatic send_clear();
        send_beat(ACT_CLEAR, random_fields());
    endtask

    // drop valid, drain all results, let slow control beats finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_mix.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_delay(input logic [DELAY_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        max_lag = value;
        cfg_writes++;
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0:       return sample_t'(SAT_HI);
            1:       return sample_t'(SAT_LO);
            2:       return sample_t'($urandom_range(0, 512)) - sample_t'(256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [DELAY_W-1:0] pick_lag();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DELAY_W'($urandom_range(41, 3000));
            2:       return DELAY_W'($urandom);
            3:       return '1;
            default: return DELAY_W'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return UNITY_GAIN;
            1:       return '0;
            2:       return '1;
            3, 4:    return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 4096));
        endcase
    endfunction

    task automatic run_random_mix(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_sample(pick_sample(), pick_sample());
            else if (pick < 84)
                send_tap($urandom_range(0, TAPS-1), pick_lag(), $urandom_range(0, 2) != 0);
            else if (pick < 99)
                send_gain($urandom_range(0, TAPS-1), pick_gain());
            else
                send_clear();
        end
    endtask

    // edge values, rounding ties, saturation, far taps, clear
    task automatic test_directed_cases();
        send_sample(sample_t'(100), -sample_t'(100));
        send_tap(0, 16'd0, 1'b1);
        send_sample(sample_t'(SAT_HI), sample_t'(SAT_LO));
        send_gain(TAPS-1, '1);
        send_tap(TAPS-1, 16'd1, 1'b1);
        send_sample(sample_t'(SAT_LO), sample_t'(SAT_HI));
        send_tap(0, 16'd0, 1'b0);
        send_gain(TAPS-1, 16'd4096);
        send_tap(TAPS-1, 16'd0, 1'b1);
        send_sample(sample_t'(1), -sample_t'(1));
        send_sample(sample_t'(3), -sample_t'(3));
        send_tap(5, '1, 1'b1);
        send_tap(3, 16'd1, 1'b1);
        send_gain(3, '0);
        send_sample(sample_t'(SAT_HI), sample_t'(SAT_HI));
        send_gain(3, UNITY_GAIN);
        send_clear();
        send_sample(sample_t'(7), sample_t'(-9));
        send_sample(sample_t'(-8), sample_t'(11));
    endtask

    // taps at the limit count, taps past it are skipped
    task automatic test_max_delay_edges();
        send_tap(0, 16'd0, 1'b1);
        send_tap(1, 16'd1, 1'b1);
        write_max_delay('0);
        repeat (3) send_sample(pick_sample(), pick_sample());
        write_max_delay(16'd1);
        repeat (3) send_sample(pick_sample(), pick_sample());
        write_max_delay('1);
        repeat (3) send_sample(pick_sample(), pick_sample());
    endtask

    task automatic test_random_traffic();
        logic [DELAY_W-1:0] limits [4];
        limits[0] = DELAY_W'($urandom_range(0, 40));
        limits[1] = DELAY_W'($urandom);
        limits[2] = DELAY_W'($urandom_range(1, 8));
        limits[3] = '1;
        foreach (limits[k]) begin
            write_max_delay(limits[k]);
            run_random_mix(340);
        end
    endtask

    // result side holds off while input keeps coming
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_sample(pick_sample(), pick_sample());
        gaps_on = 1'b1;
    endtask

    task automatic test_quiet_tail();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random_mix(250);
    endtask

    // result side ready pattern
    initial begin : result_sink
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    task automatic flag_mismatch(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        stereo_t got;
        stereo_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = stereo_t'(m_tdata[2*SW-1:0]);
            if (expected_mix.size() == 0) begin
                flag_mismatch($sformatf("unexpected result left %0d right %0d",
                    got.left, got.right));
            end else begin
                want = expected_mix.pop_front();
                mix_checked++;
                if (got.left !== want.left)
                    flag_mismatch($sformatf("left_out expected %0d got %0d",
                        want.left, got.left));
                if (got.right !== want.right)
                    flag_mismatch($sformatf("right_out expected %0d got %0d",
                        want.right, got.right));
            end
        end
    end

    initial begin : run_sequence
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= ACT_SAMPLE;
        reset_echo_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_max_delay_edges();
        test_random_traffic();
        test_output_backpressure();
        test_quiet_tail();
        wait_idle();

        $display("testbench: %0d sample beats, %0d tap table writes, %0d memory clears",
            samples_sent, tap_writes, clears_sent);
        $display("testbench: %0d mixes checked over %0d max-delay settings, long output hold",
            mix_checked, cfg_writes);
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/smtd_pkg.sv
hw/rtl/smtd_mac.sv
hw/rtl/stereo_multitap_delay_unit.sv
hw/rtl/smtd_checker.sv
tb/testbench.sv
